@@ rtl/tcw_pkg.sv @@
// ============================================================================
// tcw_pkg - shared definitions for the text console writer
// Screen geometry, cell encoding, action codes and the command and status
// structures that pass between the controller and the datapath.
// ============================================================================
package tcw_pkg;

    // Screen geometry
    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
    localparam int COPY_COUNT  = SCREEN_COLS * (SCREEN_ROWS - 1);

    // Cell store addressing; the sweep counter can also hold CELL_COUNT itself
    localparam int ADDR_W  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int SWEEP_W = $clog2(CELL_COUNT + 1);

    // Field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CELL_W = 16;

    // Characters and attributes
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] RESET_COLOR  = 8'h07;

    // Configuration port
    localparam int          PADDR_W        = 3;
    localparam int          PDATA_W        = 32;
    localparam logic        REG_TEXT_COLOR = 1'b0;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [SWEEP_W-1:0] sweep_t;
    typedef logic [CELL_W-1:0]  cell_t;

    typedef enum logic [1:0] {
        ACT_PUT_CHAR = 2'd0,
        ACT_PUT_AT   = 2'd1,
        ACT_READ     = 2'd2,
        ACT_CLEAR    = 2'd3
    } action_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;   // capture the request, clear the result
        logic wr_cell;   // write the request's cell
        logic rd_cell;   // read the cell at the given position
        logic take_rd;   // latch read data as the result entry
        logic set_bad;   // flag an off-screen position
        logic cur_step;  // advance the cursor after a put-char or newline
        logic cur_home;  // cursor to the top left corner
        logic sweep_clr; // sweep counter to zero
        logic sweep_inc; // sweep counter up by one
        logic copy_rd;   // read one row below the sweep address for a scroll
        logic fill_wr;   // write a blank at the sweep address
        logic fill_rst;  // blanks take the reset attribute
        logic out_load;  // move the result into the output register
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        action_t act;
        logic    newline;
        logic    bad;
        logic    scroll_needed;
        logic    copy_last;
        logic    sweep_end;
    } dp_status_t;

    // Character in the low byte, attribute in the high byte
    function automatic cell_t make_cell(input logic [7:0] ch, input logic [7:0] attr);
        return {attr, ch};
    endfunction

    // Linear cell address of a screen position
    function automatic addr_t cell_addr(input logic [ROW_W-1:0] row,
                                        input logic [COL_W-1:0] col);
        sweep_t lin;
        lin = sweep_t'(row) * sweep_t'(SCREEN_COLS) + sweep_t'(col);
        return lin[ADDR_W-1:0];
    endfunction

endpackage

@@ rtl/tcw_in_if.sv @@
// ============================================================================
// tcw_in_if - request channel of the text console writer
// Valid/ready channel that carries one action and its operands per transfer.
// ============================================================================
interface tcw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] char_code;
    logic [7:0] cell_color;
    logic [6:0] col;
    logic [4:0] row;

    modport source (output valid, action, char_code, cell_color, col, row,
                    input  ready);
    modport sink   (input  valid, action, char_code, cell_color, col, row,
                    output ready);
endinterface

@@ rtl/tcw_out_if.sv @@
// ============================================================================
// tcw_out_if - result channel of the text console writer
// Valid/ready channel that carries one result per transfer.
// ============================================================================
interface tcw_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] cell_entry;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        scrolled;
    logic        bad_position;

    modport source (output valid, cell_entry, cursor_row, cursor_col, scrolled,
                           bad_position,
                    input  ready);
    modport sink   (input  valid, cell_entry, cursor_row, cursor_col, scrolled,
                           bad_position,
                    output ready);
endinterface

@@ rtl/tcw_ram.sv @@
// ============================================================================
// tcw_ram - generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ============================================================================
module tcw_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 2000,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/tcw_datapath.sv @@
// ============================================================================
// tcw_datapath - cell store, cursor and result registers
// Holds the request operands, the cursor, the sweep counter used by clear
// and scroll passes, the screen cell RAM and the output register.
// ============================================================================
module tcw_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          action,
    input  logic [7:0]          char_code,
    input  logic [7:0]          cell_color,
    input  logic [6:0]          col,
    input  logic [4:0]          row,
    input  logic [7:0]          text_color,
    input  tcw_pkg::dp_cmd_t    cmd,
    output tcw_pkg::dp_status_t st,
    output logic [15:0]         cell_entry,
    output logic [4:0]          cursor_row,
    output logic [6:0]          cursor_col,
    output logic                scrolled,
    output logic                bad_position
);
    import tcw_pkg::*;

    // Captured request
    action_t          act_reg;
    logic [7:0]       ch_reg;
    logic [7:0]       attr_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;

    // Cursor and sweep state
    logic [ROW_W-1:0] cur_row_reg;
    logic [COL_W-1:0] cur_col_reg;
    sweep_t           sweep_reg;
    logic             pend_reg;
    addr_t            pend_addr_reg;

    // Result and output registers
    cell_t            entry_reg;
    logic             scrolled_reg;
    logic             bad_reg;
    cell_t            out_entry_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [COL_W-1:0] out_col_reg;
    logic             out_scrolled_reg;
    logic             out_bad_reg;

    // RAM ports
    logic  wr_en;
    addr_t wr_addr;
    cell_t wr_data;
    logic  rd_en;
    addr_t rd_addr;
    cell_t rd_data;

    logic  is_newline;
    logic  wrap;
    logic  last_row;
    addr_t cursor_addr;
    addr_t pos_addr;
    addr_t sweep_addr;
    addr_t copy_src;
    cell_t item_cell;
    addr_t item_addr;
    logic [7:0] fill_attr;

    // Position decode and cursor conditions
    assign is_newline  = (ch_reg == NEWLINE_CHAR);
    assign wrap        = is_newline || ((32'(cur_col_reg) + 1) == SCREEN_COLS);
    assign last_row    = (32'(cur_row_reg) == SCREEN_ROWS - 1);
    assign cursor_addr = cell_addr(cur_row_reg, cur_col_reg);
    assign pos_addr    = cell_addr(row_reg, col_reg);
    assign sweep_addr  = sweep_reg[ADDR_W-1:0];
    assign copy_src    = addr_t'(sweep_reg + sweep_t'(SCREEN_COLS));
    assign item_addr   = (act_reg == ACT_PUT_CHAR) ? cursor_addr : pos_addr;
    assign item_cell   = (act_reg == ACT_PUT_CHAR) ? make_cell(ch_reg, text_color)
                                                   : make_cell(ch_reg, attr_reg);
    assign fill_attr   = cmd.fill_rst ? RESET_COLOR : text_color;

    // Status to the controller
    assign st.act           = act_reg;
    assign st.newline       = is_newline;
    assign st.bad           = (32'(col_reg) >= SCREEN_COLS) || (32'(row_reg) >= SCREEN_ROWS);
    assign st.scroll_needed = wrap && last_row;
    assign st.copy_last     = (sweep_reg == sweep_t'(COPY_COUNT - 1));
    assign st.sweep_end     = (sweep_reg == sweep_t'(CELL_COUNT - 1));

    // Write port: a pending scroll copy, then fills, then single cell writes
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = sweep_addr;
        wr_data = make_cell(BLANK_CHAR, fill_attr);
        if (pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_reg;
            wr_data = rd_data;
        end
        else if (cmd.fill_wr)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.wr_cell)
        begin
            wr_en   = 1'b1;
            wr_addr = item_addr;
            wr_data = item_cell;
        end
    end

    // Read port: scroll copy source or the requested position
    assign rd_en   = cmd.rd_cell || cmd.copy_rd;
    assign rd_addr = cmd.copy_rd ? copy_src : pos_addr;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_cells (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Cursor, sweep counter and pending copy write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            sweep_reg   <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.copy_rd;
            if (cmd.cur_home)
            begin
                cur_row_reg <= '0;
                cur_col_reg <= '0;
            end
            else if (cmd.cur_step)
            begin
                if (wrap)
                begin
                    cur_col_reg <= '0;
                    if (!last_row)
                    begin
                        cur_row_reg <= cur_row_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    cur_col_reg <= cur_col_reg + COL_W'(1);
                end
            end
            if (cmd.sweep_clr)
            begin
                sweep_reg <= '0;
            end
            else if (cmd.sweep_inc)
            begin
                sweep_reg <= sweep_reg + SWEEP_W'(1);
            end
        end
    end

    // Request capture, result and output registers
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= sweep_addr;
        if (cmd.load_in)
        begin
            act_reg      <= action_t'(action);
            ch_reg       <= char_code;
            attr_reg     <= cell_color;
            col_reg      <= col;
            row_reg      <= row;
            entry_reg    <= '0;
            scrolled_reg <= 1'b0;
            bad_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.wr_cell)
            begin
                entry_reg <= item_cell;
            end
            if (cmd.take_rd)
            begin
                entry_reg <= rd_data;
            end
            if (cmd.set_bad)
            begin
                bad_reg <= 1'b1;
            end
            if (cmd.cur_step)
            begin
                scrolled_reg <= wrap && last_row;
            end
        end
        if (cmd.out_load)
        begin
            out_entry_reg    <= entry_reg;
            out_row_reg      <= cur_row_reg;
            out_col_reg      <= cur_col_reg;
            out_scrolled_reg <= scrolled_reg;
            out_bad_reg      <= bad_reg;
        end
    end

    assign cell_entry   = out_entry_reg;
    assign cursor_row   = out_row_reg;
    assign cursor_col   = out_col_reg;
    assign scrolled     = out_scrolled_reg;
    assign bad_position = out_bad_reg;

endmodule

@@ rtl/tcw_ctrl.sv @@
// ============================================================================
// tcw_ctrl - sequencing controller of the text console writer
// Runs the clearing pass after reset, decodes each request, steps the scroll
// and clear sweeps, and hands finished results to the output register.
// ============================================================================
module tcw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  tcw_pkg::dp_status_t st,
    output tcw_pkg::dp_cmd_t    cmd
);
    import tcw_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_READ_WAIT,
        ST_COPY,
        ST_DRAIN,
        ST_FILL,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.fill_wr   = 1'b1;
                cmd.fill_rst  = 1'b1;
                cmd.sweep_inc = 1'b1;
                if (st.sweep_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_FINISH;
                case (st.act)
                    ACT_PUT_CHAR:
                    begin
                        cmd.wr_cell  = !st.newline;
                        cmd.cur_step = 1'b1;
                        if (st.scroll_needed)
                        begin
                            cmd.sweep_clr = 1'b1;
                            if (COPY_COUNT > 0)
                            begin
                                state_next = ST_COPY;
                            end
                            else
                            begin
                                state_next = ST_FILL;
                            end
                        end
                    end
                    ACT_PUT_AT:
                    begin
                        cmd.set_bad = st.bad;
                        cmd.wr_cell = !st.bad;
                    end
                    ACT_READ:
                    begin
                        cmd.set_bad = st.bad;
                        cmd.rd_cell = !st.bad;
                        if (!st.bad)
                        begin
                            state_next = ST_READ_WAIT;
                        end
                    end
                    default:
                    begin
                        cmd.cur_home  = 1'b1;
                        cmd.sweep_clr = 1'b1;
                        state_next    = ST_FILL;
                    end
                endcase
            end
            ST_READ_WAIT:
            begin
                cmd.take_rd = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_COPY:
            begin
                cmd.copy_rd   = 1'b1;
                cmd.sweep_inc = 1'b1;
                if (st.copy_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // The last copied cell is written back in this cycle.
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                cmd.fill_wr   = 1'b1;
                cmd.sweep_inc = 1'b1;
                if (st.sweep_end)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid: set on load, cleared when the result transfers
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/text_console_writer.sv @@
// ============================================================================
// text_console_writer - text screen with cursor, wrap and scroll
// Top level: APB configuration register, controller and datapath.
// ============================================================================
// After reset the block runs a clearing pass that writes a blank in light grey
// on black to every one of the 2000 cells, one cell per cycle; requests are
// first accepted once that pass is done. Configuration writes are taken at
// any time. A put-char, newline or put-entry goes from acceptance through
// decode to a finish state that loads the output register; a cell read adds
// a wait state for the registered read port of the cell RAM. A put-char or
// newline that scrolls copies the 1920 cells of the lower rows up one row
// through the single read and write port, finishes the last copy, then writes
// 80 blanks; a clear homes the cursor and blanks all 2000 cells, one cell per
// cycle. A new request is accepted while the previous result still waits in
// the output register; its result is held back until that register is free.
// ============================================================================
module text_console_writer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]   paddr,
    input  logic [tcw_pkg::PDATA_W-1:0]   pwdata,
    output logic [tcw_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    tcw_in_if.sink                        request,
    tcw_out_if.source                     result
);
    import tcw_pkg::*;

    logic       [7:0] text_color_reg;
    logic             reg_sel;
    logic             cfg_write;
    dp_cmd_t          cmd;
    dp_status_t       st;

    // Configuration register decode
    assign pready    = 1'b1;
    assign reg_sel   = (paddr[PADDR_W-1] == REG_TEXT_COLOR);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= RESET_COLOR;
        end
        else if (cfg_write && reg_sel)
        begin
            text_color_reg <= pwdata[7:0];
        end
    end

    assign prdata = reg_sel ? {{(PDATA_W-8){1'b0}}, text_color_reg} : '0;

    // Controller
    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .st        (st),
        .cmd       (cmd)
    );

    // Datapath
    tcw_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .action       (request.action),
        .char_code    (request.char_code),
        .cell_color   (request.cell_color),
        .col          (request.col),
        .row          (request.row),
        .text_color   (text_color_reg),
        .cmd          (cmd),
        .st           (st),
        .cell_entry   (result.cell_entry),
        .cursor_row   (result.cursor_row),
        .cursor_col   (result.cursor_col),
        .scrolled     (result.scrolled),
        .bad_position (result.bad_position)
    );

endmodule
